FILE: design/button_gesture_classifier_top_macros.svh
// Assertion macros for the button gesture classifier.
// Used by the checker that is bound to the top level; depends on nothing else.
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bgc_pkg.sv
// Shared types and codes for the button gesture classifier.
// No dependencies; used by the classify unit, the top level and the checker.
package bgc_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_EXPIRE  = 2'd2;

    // Event kinds on the result channel.
    localparam logic [2:0] KIND_DOWN   = 3'd0;
    localparam logic [2:0] KIND_UP     = 3'd1;
    localparam logic [2:0] KIND_CLICK  = 3'd2;
    localparam logic [2:0] KIND_DOUBLE = 3'd3;
    localparam logic [2:0] KIND_LONG   = 3'd4;

    // Most click events that one expiry transaction may produce.
    localparam int RESULT_CAP = 5;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    // Operation applied by the classify unit to one button entry.
    typedef enum logic [1:0] {
        OP_PRESS,
        OP_RELEASE,
        OP_WALK
    } t_op;

    // Per-button state.
    typedef struct packed {
        logic       held;
        logic [1:0] tally;
        logic       flag;
    } t_entry;

    // Outcome of one classify step.
    typedef struct packed {
        logic       emit;
        logic       more;
        logic [2:0] kind;
        t_entry     next;
    } t_step;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_LONG,
        ST_WALK,
        ST_DRAIN
    } t_state;

endpackage

FILE: design/bgc_classify.sv
// Classify unit: applies one operation to one button entry.
// Depends on bgc_pkg; shared by the press, release and walk steps of the top-level sequencer.
module bgc_classify (
    input  bgc_pkg::t_op    i_op,
    input  bgc_pkg::t_entry i_entry,
    output bgc_pkg::t_step  o_step
);
    import bgc_pkg::*;

    // Decide the event and the updated entry for the selected operation.
    always_comb begin
        o_step      = '0;
        o_step.next = i_entry;
        case (i_op)
            OP_PRESS: begin
                o_step.emit       = 1'b1;
                o_step.kind       = KIND_DOWN;
                o_step.next.held  = 1'b1;
                if (i_entry.tally != 2'd3) begin
                    o_step.next.tally = i_entry.tally + 2'd1;
                end
            end
            OP_RELEASE: begin
                o_step.emit      = 1'b1;
                o_step.kind      = KIND_UP;
                o_step.more      = i_entry.flag;
                o_step.next.held = 1'b0;
                if (i_entry.flag) begin
                    o_step.next.tally = 2'd0;
                    o_step.next.flag  = 1'b0;
                end
            end
            OP_WALK: begin
                if (i_entry.held) begin
                    o_step.next.flag = 1'b1;
                end else begin
                    o_step.emit       = (i_entry.tally == 2'd1) || (i_entry.tally == 2'd2);
                    o_step.kind       = (i_entry.tally == 2'd1) ? KIND_CLICK : KIND_DOUBLE;
                    o_step.next.tally = 2'd0;
                end
            end
            default: begin
                o_step = '0;
                o_step.next = i_entry;
            end
        endcase
    end

endmodule

FILE: design/button_gesture_classifier_top.sv
// Button gesture classifier, top level.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per press,
// release or window-timer expiry. A transaction is taken at a rising edge with
// i_in_valid high and o_in_stall low. The block takes one transaction at a time
// and raises o_in_stall until every event it causes is in the output register.
// Result channel (o_out_valid / i_out_stall) carries one event per transaction
// of that channel; o_last_event marks the final event of an input transaction.
// A press emits one event; a release emits an up event, then a long-press event
// if the button was held across an expiry. An expiry walks one button per cycle
// through the shared classify unit, but pauses while a new click must push out
// the pending one and the output register is full; the walk and the one-event
// output register set that rate. Press or release with an out-of-range button,
// and unknown commands, are taken and dropped with no events.
// While i_out_stall is high the output register holds its event; the sequencer
// waits whenever it has a new event and the register is still full.
// Reset (synchronous, active low) clears all per-button state, the sequencer
// and the output register.
module button_gesture_classifier_top #(
    parameter int NUM_BUTTONS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [2:0] i_button_id,
    input  logic       i_timer_idle,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_event_button,
    output logic [2:0] o_event_kind,
    output logic       o_start_timer,
    output logic       o_last_event
);
    import bgc_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    // Sequencer and button state registers.
    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [IDX_W-1:0] r_sel, n_sel;
    logic             r_idle, n_idle;
    t_entry           r_ent [NUM_BUTTONS];

    // Pending click event held back until the walk knows whether it is last.
    logic             r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0] r_pend_btn, n_pend_btn;
    logic [2:0]       r_pend_kind, n_pend_kind;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_out_button, n_out_button;
    logic [2:0]       r_out_kind, n_out_kind;
    logic             r_out_start, n_out_start;
    logic             r_out_last, n_out_last;

    logic             out_free;
    logic             load;
    logic             wr_en;
    t_entry           rd_entry;
    t_step            step;
    t_op              unit_op;

    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_entry = r_ent[r_sel];
    assign unit_op  = r_op;

    bgc_classify u_classify (
        .i_op    (unit_op),
        .i_entry (rd_entry),
        .o_step  (step)
    );

    // Next state, entry writes and output loads.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_sel        = r_sel;
        n_idle       = r_idle;
        n_pend_valid = r_pend_valid;
        n_pend_btn   = r_pend_btn;
        n_pend_kind  = r_pend_kind;
        n_cnt        = r_cnt;
        load         = 1'b0;
        wr_en        = 1'b0;
        n_out_button = r_out_button;
        n_out_kind   = r_out_kind;
        n_out_start  = r_out_start;
        n_out_last   = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_idle = i_timer_idle;
                    case (i_command)
                        CMD_PRESS, CMD_RELEASE: begin
                            if (int'(i_button_id) < NUM_BUTTONS) begin
                                n_state = ST_SINGLE;
                                n_sel   = IDX_W'(i_button_id);
                                n_op    = (i_command == CMD_PRESS) ? OP_PRESS : OP_RELEASE;
                            end
                        end
                        CMD_EXPIRE: begin
                            n_state      = ST_WALK;
                            n_sel        = '0;
                            n_op         = OP_WALK;
                            n_pend_valid = 1'b0;
                            n_cnt        = '0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    load         = 1'b1;
                    wr_en        = 1'b1;
                    n_out_button = 3'(r_sel);
                    n_out_kind   = step.kind;
                    n_out_start  = (r_op == OP_PRESS) && r_idle;
                    n_out_last   = !step.more;
                    n_state      = step.more ? ST_LONG : ST_IDLE;
                end
            end
            ST_LONG: begin
                if (out_free) begin
                    load         = 1'b1;
                    n_out_button = 3'(r_sel);
                    n_out_kind   = KIND_LONG;
                    n_out_start  = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_WALK: begin
                // A new click must first push the pending one out.
                if (!(step.emit && (int'(r_cnt) < RESULT_CAP) && r_pend_valid && !out_free)) begin
                    wr_en = 1'b1;
                    if (step.emit && (int'(r_cnt) < RESULT_CAP)) begin
                        if (r_pend_valid) begin
                            load         = 1'b1;
                            n_out_button = 3'(r_pend_btn);
                            n_out_kind   = r_pend_kind;
                            n_out_start  = 1'b0;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_btn   = r_sel;
                        n_pend_kind  = step.kind;
                        n_cnt        = r_cnt + CNT_W'(1);
                    end
                    if (r_sel == LAST_IDX) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_sel = r_sel + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    load         = 1'b1;
                    n_out_button = 3'(r_pend_btn);
                    n_out_kind   = r_pend_kind;
                    n_out_start  = 1'b0;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    // State register and control flops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_sel        <= '0;
            r_op         <= OP_PRESS;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
            r_sel        <= n_sel;
            r_op         <= n_op;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idle       <= n_idle;
        r_pend_btn   <= n_pend_btn;
        r_pend_kind  <= n_pend_kind;
        r_out_button <= n_out_button;
        r_out_kind   <= n_out_kind;
        r_out_start  <= n_out_start;
        r_out_last   <= n_out_last;
    end

    // Per-button state, written at the selected button.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_ent[b] <= '0;
            end
        end else if (wr_en) begin
            r_ent[r_sel] <= step.next;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_event_button = r_out_button;
    assign o_event_kind   = r_out_kind;
    assign o_start_timer  = r_out_start;
    assign o_last_event   = r_out_last;

endmodule

FILE: design/bgc_checker.sv
// Port-level checker for the button gesture classifier, bound to the top level.
// Depends on bgc_pkg and button_gesture_classifier_top_macros.svh.
`include "button_gesture_classifier_top_macros.svh"

module bgc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_event_button,
    input logic [2:0] o_event_kind,
    input logic       o_start_timer,
    input logic       o_last_event
);
    import bgc_pkg::*;

    // A timer start request only travels with a down event.
    `BGC_ASSERT_IMPLY(a_start_on_down, i_clk, i_rst_n, o_out_valid && o_start_timer, o_event_kind == KIND_DOWN, "start_timer on a non-down event")

    // Down and long-press events always close their input transaction.
    `BGC_ASSERT_IMPLY(a_down_last, i_clk, i_rst_n, o_out_valid && (o_event_kind == KIND_DOWN || o_event_kind == KIND_LONG), o_last_event, "down or long press not marked last")

    // While more events of a transaction are due, no new input is taken.
    `BGC_ASSERT_IMPLY(a_busy_until_last, i_clk, i_rst_n, o_out_valid && !o_last_event, o_in_stall, "input taken before the last event")

    // An up event that is not last is followed directly by its long press.
    `BGC_ASSERT_NEXT(a_long_follows_up, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_event_kind == KIND_UP && !o_last_event, o_out_valid && o_event_kind == KIND_LONG && $stable(o_event_button), "long press does not follow its up event")

endmodule

bind button_gesture_classifier_top bgc_checker u_bgc_checker (.*);

FILE: bench/tb_button_gesture_classifier_top.sv
// Self-checking testbench for button_gesture_classifier_top.
// Depends on bgc_pkg and the top level. It predicts every gesture event from its
// own per-button model and checks the result channel under random stalls.
`timescale 1ns / 1ps

module tb_button_gesture_classifier_top;
    import bgc_pkg::*;

    localparam int NUM_BUTTONS  = 5;
    localparam int ITEMS_TARGET = 410;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 20;

    // One expected event on the result channel.
    typedef struct packed {
        logic [2:0] button;
        logic [2:0] kind;
        logic       start;
        logic       last;
    } t_gesture_event;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [1:0] i_command    = CMD_PRESS;
    logic [2:0] i_button_id  = 3'd0;
    logic       i_timer_idle = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_event_button;
    logic [2:0] o_event_kind;
    logic       o_start_timer;
    logic       o_last_event;

    // Predictor state, one entry per button.
    logic       btn_held  [NUM_BUTTONS];
    logic [1:0] btn_tally [NUM_BUTTONS];
    logic       btn_long  [NUM_BUTTONS];

    t_gesture_event pending_events[$];

    int  failures        = 0;
    int  items_counted   = 0;
    int  items_ignored   = 0;
    int  events_checked  = 0;
    int  long_press_seen = 0;
    int  widest_expiry   = 0;
    bit  idle_enable     = 1'b0;
    bit  timer_running   = 1'b0;

    // Long receiver hold-offs: requested by the tests, counted out by the receiver.
    int  long_holds_requested = 0;
    int  long_holds_done      = 0;
    int  rx_left              = 0;
    bit  rx_stalling          = 1'b0;

    button_gesture_classifier_top #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_button_id    (i_button_id),
        .i_timer_idle   (i_timer_idle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_button (o_event_button),
        .o_event_kind   (o_event_kind),
        .o_start_timer  (o_start_timer),
        .o_last_event   (o_last_event)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Gesture predictor: updates the button state for one accepted transaction
    // and queues the events that it causes.
    function automatic void predict_gesture_events(input logic [1:0] cmd,
                                                   input logic [2:0] id,
                                                   input logic idle);
        t_gesture_event batch [RESULT_CAP];
        int n;
        n = 0;
        if ((cmd == CMD_PRESS || cmd == CMD_RELEASE) && id < NUM_BUTTONS) begin
            if (cmd == CMD_PRESS) begin
                btn_held[id] = 1'b1;
                batch[n++] = '{id, KIND_DOWN, idle, 1'b0};
                if (btn_tally[id] != 2'd3) begin
                    btn_tally[id] = btn_tally[id] + 2'd1;
                end
            end else begin
                btn_held[id] = 1'b0;
                batch[n++] = '{id, KIND_UP, 1'b0, 1'b0};
                if (btn_long[id]) begin
                    btn_tally[id] = 2'd0;
                    btn_long[id] = 1'b0;
                    batch[n++] = '{id, KIND_LONG, 1'b0, 1'b0};
                end
            end
        end else if (cmd == CMD_EXPIRE) begin
            // Walk the buttons in index order; held buttons turn into long presses.
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (!btn_held[i]) begin
                    if ((btn_tally[i] == 2'd1 || btn_tally[i] == 2'd2) && n < RESULT_CAP) begin
                        batch[n++] = '{3'(i), (btn_tally[i] == 2'd1) ? KIND_CLICK : KIND_DOUBLE,
                                       1'b0, 1'b0};
                    end
                    btn_tally[i] = 2'd0;
                end else begin
                    btn_long[i] = 1'b1;
                end
            end
            if (n > widest_expiry) begin
                widest_expiry = n;
            end
        end else begin
            items_ignored++;
            return;
        end
        items_counted++;
        if (n > 0) begin
            batch[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_events.push_back(batch[i]);
        end
    endfunction

    // Gap length for the sender: mostly short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_enable || roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one transaction, wait until it is taken, then predict it.
    task automatic send_item(input logic [1:0] cmd, input logic [2:0] id, input logic idle);
        int gap;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_button_id  <= id;
        i_timer_idle <= idle;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_gesture_events(cmd, id, idle);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A press reports the timer idle unless an earlier press started it; now and
    // then the flag is random.
    task automatic press_button(input int b);
        logic idle;
        idle = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : !timer_running;
        send_item(CMD_PRESS, 3'(b), idle);
        if (idle) begin
            timer_running = 1'b1;
        end
    endtask

    task automatic send_expiry();
        send_item(CMD_EXPIRE, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        timer_running = 1'b0;
    endtask

    // Stop offering transactions until every expected event has come out.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver: random stalls, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_left = 0;
            rx_stalling = 1'b0;
        end else if (long_holds_done != long_holds_requested) begin
            long_holds_done++;
            rx_left = LONG_HOLD;
            rx_stalling = 1'b1;
        end else if (rx_left > 0) begin
            rx_left--;
        end else if (!idle_enable) begin
            rx_stalling = 1'b0;
        end else begin
            rx_stalling = ($urandom_range(0, 2) == 0);
            rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
        end
        i_out_stall <= rx_stalling;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // Result checker: each accepted event against the oldest expectation.
    always @(posedge i_clk) begin
        t_gesture_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event: expected none, actual button %0d kind %0d",
                         $time, o_event_button, o_event_kind);
                failures++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_button", int'(want.button), int'(o_event_button));
                check_field("event_kind", int'(want.kind), int'(o_event_kind));
                check_field("start_timer", int'(want.start), int'(o_start_timer));
                check_field("last_event", int'(want.last), int'(o_last_event));
                if (want.kind == KIND_LONG) begin
                    long_press_seen++;
                end
                events_checked++;
            end
        end
    end

    // Downs and ups on the edge buttons, timer idle both ways, release while up.
    task automatic test_press_release();
        send_item(CMD_PRESS, 3'd0, 1'b1);
        send_item(CMD_RELEASE, 3'd0, 1'b0);
        send_item(CMD_PRESS, 3'd4, 1'b0);
        send_item(CMD_RELEASE, 3'd4, 1'b1);
        send_item(CMD_RELEASE, 3'd2, 1'b1);
        send_item(CMD_EXPIRE, 3'd7, 1'b0);
    endtask

    // Double click, tally saturation and an expiry with nothing to report.
    task automatic test_window_expiry();
        send_item(CMD_PRESS, 3'd1, 1'b1);
        send_item(CMD_RELEASE, 3'd1, 1'b0);
        send_item(CMD_PRESS, 3'd1, 1'b0);
        send_item(CMD_RELEASE, 3'd1, 1'b0);
        repeat (4) send_item(CMD_PRESS, 3'd3, 1'b0);
        send_item(CMD_RELEASE, 3'd3, 1'b0);
        send_item(CMD_EXPIRE, 3'd0, 1'b1);
        send_item(CMD_EXPIRE, 3'd5, 1'b0);
    endtask

    // A button held across an expiry reports a long press on release.
    task automatic test_long_press();
        send_item(CMD_PRESS, 3'd2, 1'b1);
        send_item(CMD_EXPIRE, 3'd2, 1'b0);
        send_item(CMD_RELEASE, 3'd2, 1'b0);
    endtask

    // Unknown command and out-of-range buttons are dropped.
    task automatic test_ignored_items();
        send_item(2'd3, 3'd1, 1'b1);
        send_item(CMD_PRESS, 3'd7, 1'b1);
        send_item(CMD_RELEASE, 3'd5, 1'b0);
        send_item(CMD_PRESS, 3'd6, 1'b0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_receiver_backpressure();
        idle_enable = 1'b0;
        long_holds_requested <= long_holds_requested + 1;
        for (int i = 0; i < 8; i++) begin
            press_button(i % NUM_BUTTONS);
            send_item(CMD_RELEASE, 3'(i % NUM_BUTTONS), 1'b0);
        end
        send_expiry();
        idle_enable = 1'b1;
    endtask

    // Sender pauses until every expected event is out, then carries on.
    task automatic test_drain_pause();
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_button(b);
            send_item(CMD_RELEASE, 3'(b), 1'b0);
        end
        wait_for_drain();
        send_expiry();
    endtask

    // Random gestures with random content, and some noise.
    task automatic test_random_gestures();
        int b;
        int reps;
        while (items_counted < ITEMS_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                idle_enable = !idle_enable;
            end
            if ($urandom_range(0, 99) < 15) begin
                send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            end else begin
                b = $urandom_range(0, NUM_BUTTONS - 1);
                case ($urandom_range(0, 3))
                    0: begin
                        press_button(b);
                        send_item(CMD_RELEASE, 3'(b), 1'($urandom_range(0, 1)));
                    end
                    1, 2: begin
                        reps = $urandom_range(2, 4);
                        repeat (reps) begin
                            press_button(b);
                            send_item(CMD_RELEASE, 3'(b), 1'($urandom_range(0, 1)));
                        end
                    end
                    default: begin
                        press_button(b);
                        repeat ($urandom_range(1, 2)) send_expiry();
                        send_item(CMD_RELEASE, 3'(b), 1'($urandom_range(0, 1)));
                    end
                endcase
                if ($urandom_range(0, 99) < 40) begin
                    send_expiry();
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_held[i] = 1'b0;
            btn_tally[i] = 2'd0;
            btn_long[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_press_release();
        test_window_expiry();
        test_long_press();
        test_ignored_items();
        idle_enable = 1'b1;
        test_receiver_backpressure();
        test_drain_pause();
        test_random_gestures();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d accepted transactions and %0d dropped ones; %0d events checked.",
                 items_counted, items_ignored, events_checked);
        $display("Long presses seen: %0d; most events from one expiry: %0d.",
                 long_press_seen, widest_expiry);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
